[hw/rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, sizes and codes for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int NUM_PAGES   = 32768;
   localparam int PAGE_BYTES  = 4096;
   localparam int WORD_BITS   = 32;

   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int WORDS       = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int PAGE_IDX_W  = $clog2(NUM_PAGES);
   localparam int WORD_IDX_W  = (PAGE_IDX_W > BIT_IDX_W) ? PAGE_IDX_W - BIT_IDX_W : 1;
   localparam int SCAN_W      = WORD_IDX_W + 1;
   localparam int LIMIT_W     = PAGE_IDX_W + 1;

   localparam int SIZE_W      = 28;
   localparam int ADDR_W      = 27;
   localparam int COUNT_W     = 16;
   localparam int CFG_W       = 16;
   localparam int REQ_PAGES_W = SIZE_W + 1 - PAGE_SHIFT;

   localparam int          COUNT_MAX = (1 << COUNT_W) - 1;
   localparam logic [CFG_W-1:0] TOTAL_PAGES_RST = CFG_W'(32768);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 hit;
      logic [BIT_IDX_W-1:0] hit_bit;
      logic [LIMIT_W-1:0]   carry_out;
   } run_result_type;

   function automatic logic [LIMIT_W-1:0] clamp_limit(input logic [CFG_W-1:0] cfg);
      if (32'(cfg) > 32'(NUM_PAGES)) begin
         return LIMIT_W'(NUM_PAGES);
      end
      return LIMIT_W'(cfg);
   endfunction

endpackage

[hw/rtl/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bpa_run_finder.sv]
// ----------------------------------------------------------------------------
// bpa_run_finder
// Evaluates one bitmap word: free-run length ending at every bit, given the
// run carried in from the word below, and the lowest bit where it fits.
// ----------------------------------------------------------------------------
module bpa_run_finder
   import bpa_pkg::*;
(
   input  logic [WORD_BITS-1:0]   word,
   input  logic [WORD_IDX_W-1:0]  word_idx,
   input  logic [LIMIT_W-1:0]     carry_in,
   input  logic [REQ_PAGES_W-1:0] pages,
   input  logic [LIMIT_W-1:0]     limit,
   output run_result_type         result
);

   logic                 has_used  [WORD_BITS];
   logic [BIT_IDX_W-1:0] last_used [WORD_BITS];
   logic [LIMIT_W-1:0]   run_len   [WORD_BITS];
   logic [WORD_BITS-1:0] fits;

   // last used bit at or below each position
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         has_used[i]  = 1'b0;
         last_used[i] = '0;
         for (int j = 0; j < WORD_BITS; j++) begin
            if (j <= i && word[j]) begin
               has_used[i]  = 1'b1;
               last_used[i] = BIT_IDX_W'(j);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         if (has_used[i]) begin
            run_len[i] = LIMIT_W'(i) - LIMIT_W'(last_used[i]);
         end else begin
            run_len[i] = carry_in + LIMIT_W'(i + 1);
         end
         fits[i] = (32'(run_len[i]) >= 32'(pages)) &&
                   (((32'(word_idx) << BIT_IDX_W) + 32'(i)) < 32'(limit));
      end
   end

   always_comb begin
      result.hit       = |fits;
      result.hit_bit   = '0;
      result.carry_out = run_len[WORD_BITS-1];
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (fits[i]) begin
            result.hit_bit = BIT_IDX_W'(i);
         end
      end
   end

endmodule

[hw/rtl/bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page frame allocator over a one-bit-per-page bitmap in RAM.
// ----------------------------------------------------------------------------
// One request word at a time. After reset the bitmap RAM is swept clear, one
// word a cycle, before the first request is taken. An allocate reads the
// bitmap words in a first-fit scan (one per cycle, up to total_pages/32
// rounded up, at most 1024), then reads and writes each word touched by the
// run through the single RAM port pair. A free reads and writes each word of
// its range, clipped to the bitmap, in the same way. A zero size goes
// straight to the result, with no RAM access. The result sits in an output
// register, so the next request is taken while it waits.
module bitmap_page_allocator
   import bpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_wr_en,
   input  logic [CFG_W-1:0]     csr_wr_data,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [SIZE_W-1:0]    req_size_bytes,
   input  logic [ADDR_W-1:0]    req_address,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_ok,
   output logic [ADDR_W-1:0]    rsp_alloc_address,
   output logic [COUNT_W-1:0]   rsp_used_pages
);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]       total_pages_ff, total_pages_in;
   logic [COUNT_W-1:0]     used_count_ff, used_count_in;
   logic [WORD_IDX_W-1:0]  clr_ptr_ff, clr_ptr_in;

   logic                   op_ff, op_in;
   logic [REQ_PAGES_W-1:0] pages_ff, pages_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   ok_ff, ok_in;

   logic [SCAN_W-1:0]      scan_word_ff, scan_word_in;
   logic [WORD_IDX_W-1:0]  eval_word_ff, eval_word_in;
   logic                   data_vld_ff, data_vld_in;
   logic [LIMIT_W-1:0]     carry_ff, carry_in;
   logic [PAGE_IDX_W-1:0]  end_ff, end_in;

   logic [PAGE_IDX_W-1:0]  start_ff, start_in;
   logic [PAGE_IDX_W-1:0]  last_ff, last_in;
   logic [WORD_IDX_W-1:0]  mark_word_ff, mark_word_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [COUNT_W-1:0]     rsp_used_ff, rsp_used_in;

   logic                   accept;
   logic [REQ_PAGES_W-1:0] req_pages;
   logic [LIMIT_W-1:0]     limit;
   logic [SCAN_W-1:0]      num_words;
   logic                   scan_issue;
   logic                   scan_fail;
   logic                   scan_hit;
   logic                   clr_done;
   logic                   out_load;
   logic                   free_skip;
   logic [31:0]            free_first;
   logic [31:0]            free_last;
   logic [PAGE_IDX_W-1:0]  prep_start;
   logic [PAGE_IDX_W-1:0]  prep_last;
   logic [WORD_IDX_W-1:0]  start_word;
   logic [WORD_IDX_W-1:0]  last_word;
   logic [BIT_IDX_W-1:0]   lo_bit;
   logic [BIT_IDX_W-1:0]   hi_bit;
   logic [WORD_BITS-1:0]   mark_mask;

   logic                   ram_wr_en;
   logic [WORD_IDX_W-1:0]  ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [WORD_IDX_W-1:0]  ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;

   run_result_type         run_res;

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (1 << WORD_IDX_W)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bpa_run_finder u_finder (
      .word     (ram_rd_data),
      .word_idx (eval_word_ff),
      .carry_in (carry_ff),
      .pages    (pages_ff),
      .limit    (limit),
      .result   (run_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_pages = REQ_PAGES_W'(({1'b0, req_size_bytes} +
                      (SIZE_W + 1)'(PAGE_BYTES - 1)) >> PAGE_SHIFT);

   assign limit      = clamp_limit(total_pages_ff);
   assign num_words  = SCAN_W'(({1'b0, limit} + (LIMIT_W + 1)'(WORD_BITS - 1)) >> BIT_IDX_W);
   assign scan_issue = (state_ff == ST_SCAN) && (scan_word_ff < num_words);
   assign scan_hit   = (state_ff == ST_SCAN) && data_vld_ff && run_res.hit;
   assign scan_fail  = (state_ff == ST_SCAN) && !data_vld_ff && (scan_word_ff >= num_words);
   assign clr_done   = (clr_ptr_ff == WORD_IDX_W'(WORDS - 1));
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // free range, clipped to the bitmap
   assign free_first = 32'(addr_ff >> PAGE_SHIFT);
   assign free_last  = free_first + 32'(pages_ff) - 32'd1;
   assign free_skip  = (op_ff == OP_FREE) && (free_first >= 32'(NUM_PAGES));

   always_comb begin
      if (op_ff == OP_ALLOC) begin
         prep_start = PAGE_IDX_W'(32'(end_ff) + 32'd1 - 32'(pages_ff));
         prep_last  = end_ff;
      end else begin
         prep_start = PAGE_IDX_W'(free_first);
         if (free_last > 32'(NUM_PAGES - 1)) begin
            prep_last = PAGE_IDX_W'(NUM_PAGES - 1);
         end else begin
            prep_last = PAGE_IDX_W'(free_last);
         end
      end
   end

   // bits of the current word that fall inside the run
   assign start_word = WORD_IDX_W'(start_ff >> BIT_IDX_W);
   assign last_word  = WORD_IDX_W'(last_ff >> BIT_IDX_W);
   assign lo_bit     = (mark_word_ff == start_word) ? BIT_IDX_W'(start_ff) : '0;
   assign hi_bit     = (mark_word_ff == last_word) ? BIT_IDX_W'(last_ff) : '1;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         mark_mask[b] = (BIT_IDX_W'(b) >= lo_bit) && (BIT_IDX_W'(b) <= hi_bit);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_pages == '0) begin
                  state_in = ST_DONE;
               end else if (req_opcode == OP_ALLOC) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_PREP;
            end else if (scan_fail) begin
               state_in = ST_DONE;
            end
         end
         ST_PREP: begin
            state_in = free_skip ? ST_DONE : ST_MARK_RD;
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            state_in = (mark_word_ff == last_word) ? ST_DONE : ST_MARK_RD;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // RAM controls
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = mark_word_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = mark_word_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ptr_ff;
         end
         ST_SCAN: begin
            ram_rd_en   = scan_issue;
            ram_rd_addr = WORD_IDX_W'(scan_word_ff);
         end
         ST_MARK_RD: begin
            ram_rd_en = 1'b1;
         end
         ST_MARK_WR: begin
            ram_wr_en = 1'b1;
            if (op_ff == OP_ALLOC) begin
               ram_wr_data = ram_rd_data | mark_mask;
            end else begin
               ram_wr_data = ram_rd_data & ~mark_mask;
            end
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      total_pages_in = csr_wr_en ? csr_wr_data : total_pages_ff;
      used_count_in  = used_count_ff;
      clr_ptr_in     = clr_ptr_ff;
      op_in          = op_ff;
      pages_in       = pages_ff;
      addr_in        = addr_ff;
      ok_in          = ok_ff;
      scan_word_in   = scan_word_ff;
      eval_word_in   = eval_word_ff;
      data_vld_in    = 1'b0;
      carry_in       = carry_ff;
      end_in         = end_ff;
      start_in       = start_ff;
      last_in        = last_ff;
      mark_word_in   = mark_word_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_ok_in      = rsp_ok_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_used_in    = rsp_used_ff;

      if (state_ff == ST_CLEAR) begin
         clr_ptr_in = clr_ptr_ff + WORD_IDX_W'(1);
      end

      if (accept) begin
         op_in        = req_opcode;
         pages_in     = req_pages;
         addr_in      = req_address;
         ok_in        = 1'b0;
         scan_word_in = '0;
         carry_in     = '0;
      end

      if (state_ff == ST_SCAN) begin
         if (scan_issue) begin
            eval_word_in = WORD_IDX_W'(scan_word_ff);
            scan_word_in = scan_word_ff + SCAN_W'(1);
            data_vld_in  = 1'b1;
         end
         if (data_vld_ff) begin
            carry_in = run_res.carry_out;
            end_in   = PAGE_IDX_W'((32'(eval_word_ff) << BIT_IDX_W) + 32'(run_res.hit_bit));
         end
      end

      if (state_ff == ST_PREP) begin
         ok_in        = 1'b1;
         start_in     = prep_start;
         last_in      = prep_last;
         mark_word_in = WORD_IDX_W'(prep_start >> BIT_IDX_W);
      end

      if (state_ff == ST_MARK_WR) begin
         mark_word_in = mark_word_ff + WORD_IDX_W'(1);
      end

      if (out_load) begin
         if (ok_ff) begin
            if (op_ff == OP_ALLOC) begin
               if (32'(used_count_ff) + 32'(pages_ff) > 32'(COUNT_MAX)) begin
                  used_count_in = COUNT_W'(COUNT_MAX);
               end else begin
                  used_count_in = COUNT_W'(32'(used_count_ff) + 32'(pages_ff));
               end
            end else if (32'(used_count_ff) > 32'(pages_ff)) begin
               used_count_in = COUNT_W'(32'(used_count_ff) - 32'(pages_ff));
            end else begin
               used_count_in = '0;
            end
         end
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_ff;
         rsp_addr_in  = (ok_ff && op_ff == OP_ALLOC) ? (ADDR_W'(start_ff) << PAGE_SHIFT) : '0;
         rsp_used_in  = used_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         total_pages_ff <= TOTAL_PAGES_RST;
         used_count_ff  <= '0;
         clr_ptr_ff     <= '0;
         data_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         total_pages_ff <= total_pages_in;
         used_count_ff  <= used_count_in;
         clr_ptr_ff     <= clr_ptr_in;
         data_vld_ff    <= data_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pages_ff     <= pages_in;
      addr_ff      <= addr_in;
      ok_ff        <= ok_in;
      scan_word_ff <= scan_word_in;
      eval_word_ff <= eval_word_in;
      carry_ff     <= carry_in;
      end_ff       <= end_in;
      start_ff     <= start_in;
      last_ff      <= last_in;
      mark_word_ff <= mark_word_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_used_ff  <= rsp_used_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_alloc_address = rsp_addr_ff;
   assign rsp_used_pages    = rsp_used_ff;

endmodule

[hw/rtl/bpa_checker.sv]
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the bitmap page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker
   import bpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_ok,
   input  logic [ADDR_W-1:0]    rsp_alloc_address,
   input  logic [COUNT_W-1:0]   rsp_used_pages
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok) &&
      $stable(rsp_alloc_address) && $stable(rsp_used_pages))
      else $error("result word changed under stall");

   // busy in the cycle after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   a_fail_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_alloc_address == '0)
      else $error("failed result carries an address");

   a_addr_page_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alloc_address[PAGE_SHIFT-1:0] == '0)
      else $error("result address not page aligned");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
